### rtl/mfq_pkg.sv
// Package for the multilevel feedback queue scheduler.
// Holds transaction structs, sequencer states, status and register codes.
// No dependencies.
`timescale 1ns / 1ps

package mfq_pkg;

    // default sizing
    localparam int MFQ_QUEUE_DEPTH = 16;
    localparam int MFQ_NUM_LEVELS  = 4;
    localparam int MFQ_TIME_WIDTH  = 16;

    // fixed field widths
    localparam int QUANT_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int QUANT_REGS = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM3    = 3'd4;

    // register reset values
    localparam logic [2:0]         RST_LEVEL_COUNT = 3'd3;
    localparam logic [QUANT_W-1:0] RST_QUANTUM0    = 16'd4;
    localparam logic [QUANT_W-1:0] RST_QUANTUM1    = 16'd8;
    localparam logic [QUANT_W-1:0] RST_QUANTUM2    = 16'd16;
    localparam logic [QUANT_W-1:0] RST_QUANTUM3    = 16'd32;

    // input kinds
    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_REFUSED  = 2'd1;
    localparam logic [1:0] ST_IDLE     = 2'd2;
    localparam logic [1:0] ST_RAN      = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [3:0]  task_id;
        logic [15:0] burst_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] running_id;
        logic [1:0] running_level;
        logic       finished;
    } t_out_item;

    // flags from the shared time unit
    typedef struct packed {
        logic zero;
        logic quantum_hit;
        logic finished;
    } t_alu_flags;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARRIVE,
        S_VISIT,
        S_VISIT_EV,
        S_RUN,
        S_RUN_EV,
        S_DONE
    } t_state;

endpackage

### rtl/mfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mfq_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mfq_alu.sv
// Shared time unit: zero test, quantum compare, saturating decrement and
// quantum count increment for one queue entry. Depends on mfq_pkg.
`timescale 1ns / 1ps

module mfq_alu
    import mfq_pkg::*;
#(
    parameter int TIME_WIDTH = MFQ_TIME_WIDTH
) (
    input  logic [TIME_WIDTH-1:0] i_time,
    input  logic [QUANT_W-1:0]    i_used,
    input  logic [QUANT_W-1:0]    i_quantum,
    output logic [TIME_WIDTH-1:0] o_time_dec,
    output logic [QUANT_W-1:0]    o_used_inc,
    output t_alu_flags            o_flags
);

    // decrement without going below zero
    always_comb begin
        o_flags.zero        = (i_time == '0);
        o_flags.quantum_hit = (i_used >= i_quantum);
        o_time_dec          = o_flags.zero ? '0 : i_time - TIME_WIDTH'(1);
        o_flags.finished    = (o_time_dec == '0);
        o_used_inc          = (i_used == '1) ? i_used : i_used + QUANT_W'(1);
    end

endmodule

### rtl/multilevel_feedback_queue_scheduler.sv
// Top level of the multilevel feedback queue scheduler: sequencer, level
// ring pointers and configuration. Depends on mfq_pkg, mfq_ram, mfq_alu.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------
//  input   | in        | i_in_valid / o_in_stall   | i_in_data (t_in_item)
//  output  | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  config  | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// An arrival passes through S_ARRIVE and S_DONE from acceptance to a valid
// result. A tick visits each active level once in S_VISIT, with an extra
// S_VISIT_EV step for each non-empty one, then S_RUN, S_RUN_EV if a task
// ran, and S_DONE, since every head is read through the single read port of
// the entry RAM. One item is in work at a time; o_in_stall is low only when
// idle. A stalled result holds in the output register; the next item may
// be accepted meanwhile. Reset clears pointers and counts; no RAM sweep.
`timescale 1ns / 1ps

module multilevel_feedback_queue_scheduler
    import mfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = MFQ_QUEUE_DEPTH,
    parameter int NUM_LEVELS  = MFQ_NUM_LEVELS,
    parameter int TIME_WIDTH  = MFQ_TIME_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int DEPTH   = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = FILL_W + 1;
    localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int ACT_W   = $clog2(NUM_LEVELS + 1);
    localparam int ENTRY_W = 4 + TIME_WIDTH;
    localparam int TOT_W   = $clog2(DEPTH + 1);

    localparam logic [FILL_W-1:0] QD_F = FILL_W'(QUEUE_DEPTH);

    // control state
    t_state             r_state, n_state;
    logic [ACT_W-1:0]   r_lvl, n_lvl;
    logic [ACT_W-1:0]   r_active, n_active;
    logic [HEAD_W-1:0]  r_heads [NUM_LEVELS];
    logic [HEAD_W-1:0]  n_heads [NUM_LEVELS];
    logic [FILL_W-1:0]  r_fill  [NUM_LEVELS];
    logic [FILL_W-1:0]  n_fill  [NUM_LEVELS];
    logic [QUANT_W-1:0] r_qu    [NUM_LEVELS];
    logic [QUANT_W-1:0] n_qu    [NUM_LEVELS];
    logic [FILL_W-1:0]  r_live, n_live;
    logic               r_out_valid, n_out_valid;

    // configuration registers
    logic [2:0]         r_cfg_count;
    logic [QUANT_W-1:0] r_quantum [QUANT_REGS];

    // payload registers
    t_in_item           r_item, n_item;
    t_out_item          r_res, n_res;
    t_out_item          r_out_data, n_out_data;

    // RAM and shared unit signals
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr, w_raddr;
    logic [ENTRY_W-1:0] w_wdata, w_rdata;
    logic [3:0]         w_rd_id;
    logic [TIME_WIDTH-1:0] w_rd_time, w_time_dec;
    logic [QUANT_W-1:0] w_used_inc, w_quantum;
    t_alu_flags         w_flags;

    logic [LVL_W-1:0]   w_cur;
    logic [ACT_W-1:0]   w_dest_full;
    logic [LVL_W-1:0]   w_dest;
    logic               w_run_found;
    logic [LVL_W-1:0]   w_run_lvl;
    logic [ADDR_W-1:0]  w_head_addr;
    logic               w_in_acc, w_out_free;
    logic [TOT_W-1:0]   w_fill_sum;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lv,
                                                    input logic [HEAD_W-1:0] pos);
        return ADDR_W'(ADDR_W'(lv) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(pos);
    endfunction

    function automatic logic [HEAD_W-1:0] tail_pos(input logic [HEAD_W-1:0] head,
                                                   input logic [FILL_W-1:0] fill);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(fill);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return HEAD_W'(s);
    endfunction

    function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] head);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(1);
        return (s >= SUM_W'(QUEUE_DEPTH)) ? '0 : HEAD_W'(s);
    endfunction

    // entry store: {id, remaining time}
    mfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_id   = w_rdata[ENTRY_W-1:TIME_WIDTH];
    assign w_rd_time = w_rdata[TIME_WIDTH-1:0];

    mfq_alu #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_alu (
        .i_time     (w_rd_time),
        .i_used     (r_qu[w_cur]),
        .i_quantum  (w_quantum),
        .o_time_dec (w_time_dec),
        .o_used_inc (w_used_inc),
        .o_flags    (w_flags)
    );

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cur      = r_lvl[LVL_W-1:0];

    // quantum of the level in work; levels past the register list get zero
    always_comb begin
        w_quantum = '0;
        for (int q = 0; q < QUANT_REGS; q++) begin
            if (int'(r_lvl) == q) begin
                w_quantum = r_quantum[q];
            end
        end
    end

    // demotion target: next level, or the same one at the last active level
    always_comb begin
        w_dest_full = ((r_lvl + ACT_W'(1)) < r_active) ? r_lvl + ACT_W'(1) : r_lvl;
        w_dest      = w_dest_full[LVL_W-1:0];
    end

    // highest-priority (lowest-numbered) non-empty active level
    always_comb begin
        w_run_found = 1'b0;
        w_run_lvl   = '0;
        for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
            if ((k < int'(r_active)) && (r_fill[k] != '0)) begin
                w_run_found = 1'b1;
                w_run_lvl   = LVL_W'(k);
            end
        end
    end

    assign w_head_addr = slot_addr(w_cur, r_heads[w_cur]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in_data.kind == KIND_TICK) ? S_VISIT : S_ARRIVE;
                end
            end
            S_ARRIVE: n_state = S_DONE;
            S_VISIT: begin
                if (r_lvl >= r_active) begin
                    n_state = S_RUN;
                end else if (r_fill[w_cur] != '0) begin
                    n_state = S_VISIT_EV;
                end
            end
            S_VISIT_EV: n_state = S_VISIT;
            S_RUN: n_state = w_run_found ? S_RUN_EV : S_DONE;
            S_RUN_EV: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        int lc;
        n_lvl       = r_lvl;
        n_active    = r_active;
        n_heads     = r_heads;
        n_fill      = r_fill;
        n_qu        = r_qu;
        n_live      = r_live;
        n_item      = r_item;
        n_res       = r_res;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_waddr     = w_head_addr;
        w_wdata     = w_rdata;
        w_raddr     = w_head_addr;
        o_in_stall  = (r_state != S_IDLE);
        lc          = int'(r_cfg_count);

        case (r_state)
            S_IDLE: begin
                // capture the transaction and clamp the active level count
                if (w_in_acc) begin
                    n_item = i_in_data;
                    n_lvl  = '0;
                    if (lc < 1) begin
                        lc = 1;
                    end
                    if (lc > NUM_LEVELS) begin
                        lc = NUM_LEVELS;
                    end
                    n_active = ACT_W'(lc);
                end
            end
            S_ARRIVE: begin
                // enqueue at the tail of the top level, or refuse when full
                if (r_live >= QD_F) begin
                    n_res = '{status: ST_REFUSED, running_id: 4'd0,
                              running_level: 2'd0, finished: 1'b0};
                end else begin
                    if (r_fill[0] < QD_F) begin
                        w_we      = 1'b1;
                        w_waddr   = slot_addr('0, tail_pos(r_heads[0], r_fill[0]));
                        w_wdata   = {r_item.task_id, TIME_WIDTH'(r_item.burst_length)};
                        n_fill[0] = r_fill[0] + FILL_W'(1);
                    end
                    n_live = r_live + FILL_W'(1);
                    n_res  = '{status: ST_ACCEPTED, running_id: 4'd0,
                               running_level: 2'd0, finished: 1'b0};
                end
            end
            S_VISIT: begin
                // skip an empty level; otherwise the head read is under way
                if ((r_lvl < r_active) && (r_fill[w_cur] == '0)) begin
                    n_lvl = r_lvl + ACT_W'(1);
                end
            end
            S_VISIT_EV: begin
                if (w_flags.zero) begin
                    // drop a spent head
                    n_heads[w_cur] = head_inc(r_heads[w_cur]);
                    n_fill[w_cur]  = r_fill[w_cur] - FILL_W'(1);
                    n_qu[w_cur]    = '0;
                    if (r_live != '0) begin
                        n_live = r_live - FILL_W'(1);
                    end
                end else if (w_flags.quantum_hit) begin
                    n_qu[w_cur]    = '0;
                    n_heads[w_cur] = head_inc(r_heads[w_cur]);
                    if (w_dest == w_cur) begin
                        // rotate within the last level
                        w_we    = 1'b1;
                        w_waddr = slot_addr(w_cur, tail_pos(r_heads[w_cur], r_fill[w_cur]));
                    end else begin
                        // demote to the next level's tail
                        n_fill[w_cur] = r_fill[w_cur] - FILL_W'(1);
                        if (r_fill[w_dest] < QD_F) begin
                            w_we    = 1'b1;
                            w_waddr = slot_addr(w_dest,
                                                tail_pos(r_heads[w_dest], r_fill[w_dest]));
                            n_fill[w_dest] = r_fill[w_dest] + FILL_W'(1);
                        end
                    end
                end
                n_lvl = r_lvl + ACT_W'(1);
            end
            S_RUN: begin
                // select the run level and read its head
                w_raddr = slot_addr(w_run_lvl, r_heads[w_run_lvl]);
                if (w_run_found) begin
                    n_lvl = ACT_W'(w_run_lvl);
                end else begin
                    n_res = '{status: ST_IDLE, running_id: 4'd0,
                              running_level: 2'd0, finished: 1'b0};
                end
            end
            S_RUN_EV: begin
                // run the head for one unit and write back its time
                w_we        = 1'b1;
                w_wdata     = {w_rd_id, w_time_dec};
                n_qu[w_cur] = w_used_inc;
                n_res       = '{status: ST_RAN, running_id: w_rd_id,
                                running_level: 2'(r_lvl), finished: w_flags.finished};
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= '0;
            r_active    <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_LEVELS; k++) begin
                r_heads[k] <= '0;
                r_fill[k]  <= '0;
                r_qu[k]    <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_active    <= n_active;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
            r_heads     <= n_heads;
            r_fill      <= n_fill;
            r_qu        <= n_qu;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count  <= RST_LEVEL_COUNT;
            r_quantum[0] <= RST_QUANTUM0;
            r_quantum[1] <= RST_QUANTUM1;
            r_quantum[2] <= RST_QUANTUM2;
            r_quantum[3] <= RST_QUANTUM3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEVEL_COUNT: r_cfg_count  <= i_cfg_data[2:0];
                CFG_QUANTUM0:    r_quantum[0] <= i_cfg_data;
                CFG_QUANTUM1:    r_quantum[1] <= i_cfg_data;
                CFG_QUANTUM2:    r_quantum[2] <= i_cfg_data;
                CFG_QUANTUM3:    r_quantum[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    // total stored entries, for checking
    always_comb begin
        w_fill_sum = '0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            w_fill_sum = w_fill_sum + TOT_W'(r_fill[k]);
        end
    end

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= QD_F)
        else $error("live task count above queue depth");

    a_fill_le_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill_sum <= TOT_W'(r_live))
        else $error("stored entries exceed live tasks");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after a transaction");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && w_out_free |=> o_out_valid && (o_out_data == $past(r_res)))
        else $error("result not loaded into output register");

    a_visit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VISIT_EV) |-> (r_lvl < r_active) && (r_fill[w_cur] != '0))
        else $error("head evaluated at an empty or inactive level");

endmodule
